/* design/fpcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcs_pkg
// shared types and register indexes for the farthest-point center selector
// ----------------------------------------------------------------------------
package fpcs_pkg;

  // storage sizes, fixed by the port and register widths
  localparam int MAX_POINTS = 1024;
  localparam int MAX_DIMS   = 16;

  localparam logic [1:0] REG_NUM_POINTS  = 2'd0;
  localparam logic [1:0] REG_NUM_DIMS    = 2'd1;
  localparam logic [1:0] REG_NUM_CENTERS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK
  } fpcs_state_t;

  // distance engine control, sequencer to datapath
  typedef struct packed {
    logic pt_first;   // first dimension of a point
    logic pt_last;    // last dimension of a point
    logic first_pass; // first center after the start center
    logic pt_zero;    // point index zero
  } fpcs_ctl_t;

endpackage

/* design/fpcs_dist_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcs_dist_unit
// accumulates squared distance per point, updates the min store, tracks max
// ----------------------------------------------------------------------------
module fpcs_dist_unit
  import fpcs_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int DIST_WIDTH  = 38,
  parameter int PT_W        = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,      // pass start, checked against busy
  input  logic                          vld,        // coordinate pair valid
  input  fpcs_ctl_t                     ctl,
  input  logic [PT_W-1:0]               pt,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  output logic [PT_W-1:0]               best_pt,
  output logic                          busy
);

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * COORD_WIDTH;

  // stage 1: difference and square
  logic [SQ_W-1:0]       sq_r;
  logic                  s1_vld_r;
  fpcs_ctl_t             s1_ctl_r;
  logic [PT_W-1:0]       s1_pt_r;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]     mag;

  assign diff = DIFF_W'(a) - DIFF_W'(b);
  assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // mag is at most 2^W-1, so its low W bits square exactly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld;
    end
    sq_r     <= SQ_W'(mag[SQ_W/2-1:0]) * SQ_W'(mag[SQ_W/2-1:0]);
    s1_ctl_r <= ctl;
    s1_pt_r  <= pt;
  end

  // stage 2: accumulate over the dimensions of one point
  logic [DIST_WIDTH-1:0] acc_r, acc_nxt;
  logic                  s2_vld_r;
  fpcs_ctl_t             s2_ctl_r;
  logic [PT_W-1:0]       s2_pt_r;

  always_comb begin
    acc_nxt = (s1_ctl_r.pt_first ? '0 : acc_r) + DIST_WIDTH'(sq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && s1_ctl_r.pt_last;
    end
    if (s1_vld_r) begin
      acc_r <= acc_nxt;
    end
    s2_ctl_r <= s1_ctl_r;
    s2_pt_r  <= s1_pt_r;
  end

  // min distance memory: read issued in stage 2, data back in stage 3
  logic [DIST_WIDTH-1:0] mem [2**PT_W];
  logic [DIST_WIDTH-1:0] rd_r;
  logic [DIST_WIDTH-1:0] s3_d_r;
  logic                  s3_vld_r;
  fpcs_ctl_t             s3_ctl_r;
  logic [PT_W-1:0]       s3_pt_r;
  logic [DIST_WIDTH-1:0] new_min;
  logic                  wr_en;

  always_ff @(posedge clk) begin
    rd_r <= mem[s2_pt_r];
    if (wr_en) begin
      mem[s3_pt_r] <= new_min;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_d_r   <= acc_r;
    s3_ctl_r <= s2_ctl_r;
    s3_pt_r  <= s2_pt_r;
  end

  // each point is read once per pass, so no same-entry overlap
  assign new_min = (s3_ctl_r.first_pass || s3_d_r < rd_r) ? s3_d_r : rd_r;
  assign wr_en   = s3_vld_r;

  logic [DIST_WIDTH-1:0] best_d_r;
  logic [PT_W-1:0]       best_pt_r;

  always_ff @(posedge clk) begin
    if (s3_vld_r && (s3_ctl_r.pt_zero || new_min > best_d_r)) begin
      best_d_r  <= new_min;
      best_pt_r <= s3_pt_r;
    end
  end

  assign best_pt = best_pt_r;
  assign busy    = s1_vld_r | s2_vld_r | s3_vld_r;

  always_ff @(posedge clk) begin
    if (rst_n && start && busy) begin
      $error("pass started while distance pipe busy");
    end
  end

  property p_acc_only_on_last;
    @(posedge clk) disable iff (!rst_n) s2_vld_r |-> $past(s1_vld_r);
  endproperty
  a_acc_only_on_last: assert property (p_acc_only_on_last) else $error("stray point");

  property p_wr_follows;
    @(posedge clk) disable iff (!rst_n) s3_vld_r |-> $past(s2_vld_r);
  endproperty
  a_wr_follows: assert property (p_wr_follows) else $error("stray write");

  property p_best_range;
    @(posedge clk) disable iff (!rst_n) s3_vld_r && s3_ctl_r.pt_zero |=> best_pt_r == '0;
  endproperty
  a_best_range: assert property (p_best_range) else $error("best index not reset");

endmodule

/* design/farthest_point_center_select_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// farthest_point_center_select_top
// farthest-first center selection over a stored point set
// ----------------------------------------------------------------------------
// load words are accepted back to back while the selector is idle
// a pass reads each scan coordinate together with its center coordinate, through
//   the two read ports of the point memory
// the first result is valid the cycle after the start word is accepted
// synchronous active-low reset clears control and the load count, and sets the counts
//   configured to one; the memories hold no reset value and need no clearing pass
module farthest_point_center_select_top
  import fpcs_pkg::*;
#(
  parameter int MAX_CENTERS = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [10:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_coordinate,
  input  logic [9:0]                    in_first_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [5:0]                    out_center_rank,
  output logic [9:0]                    out_point_index,
  output logic                          out_error,
  output logic                          out_last
);

  localparam int PT_W    = $clog2(MAX_POINTS);
  localparam int DM_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int ADDR_W  = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int DIST_W  = 2 * COORD_WIDTH + 1 + $clog2(MAX_DIMS + 1);

  logic [10:0] np_cfg_r;
  logic [4:0]  nd_cfg_r;
  logic [6:0]  nc_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_cfg_r <= 11'd1;
      nd_cfg_r <= 5'd1;
      nc_cfg_r <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_POINTS:  np_cfg_r <= cfg_data;
        REG_NUM_DIMS:    nd_cfg_r <= cfg_data[4:0];
        REG_NUM_CENTERS: nc_cfg_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamped effective counts
  logic [PT_W:0]  np;
  logic [DM_W:0]  nd;
  logic [6:0]     kc;
  logic [CNT_W-1:0] total;

  always_comb begin
    if (np_cfg_r == 11'd0) np = (PT_W+1)'(1);
    else if (32'(np_cfg_r) > MAX_POINTS) np = (PT_W+1)'(MAX_POINTS);
    else np = (PT_W+1)'(np_cfg_r);
    if (nd_cfg_r == 5'd0) nd = (DM_W+1)'(1);
    else if (32'(nd_cfg_r) > MAX_DIMS) nd = (DM_W+1)'(MAX_DIMS);
    else nd = (DM_W+1)'(nd_cfg_r);
    kc = (32'(nc_cfg_r) > MAX_CENTERS) ? 7'(MAX_CENTERS) : nc_cfg_r;
  end

  assign total = CNT_W'(np) * CNT_W'(nd);

  fpcs_state_t state_r, state_nxt;
  logic [CNT_W-1:0] load_cnt_r;
  logic [PT_W-1:0]  center_r;
  logic [PT_W-1:0]  scan_pt_r;
  logic [DM_W:0]    scan_dm_r;
  logic [ADDR_W-1:0] addr_j_r, addr_c_r;
  logic [6:0]       rank_r;
  logic [2:0]       drain_r;

  // output register
  logic       ov_r;
  logic [5:0] orank_r;
  logic [9:0] oidx_r;
  logic       oerr_r, olast_r;
  logic       out_free;

  assign out_free = !ov_r || !out_stall;

  logic accept_in, start_acc, bad_start;
  assign in_stall  = (state_r != ST_IDLE) || (in_mode && !out_free);
  assign accept_in = in_valid && !in_stall;
  assign start_acc = accept_in && in_mode;
  assign bad_start = (kc == 7'd0) || (32'(kc) > 32'(np)) ||
                     (32'(in_first_index) >= 32'(np));

  // point memory with two read ports (scan point and current center)
  logic [COORD_WIDTH-1:0] pmem [MAX_POINTS * MAX_DIMS];
  logic [COORD_WIDTH-1:0] rd_j_r, rd_c_r;
  logic [CNT_W-1:0] wr_slot;

  assign wr_slot = (load_cnt_r >= total) ? '0 : load_cnt_r;

  always_ff @(posedge clk) begin
    if (accept_in && !in_mode) begin
      pmem[wr_slot[ADDR_W-1:0]] <= in_coordinate;
    end
    rd_j_r <= pmem[addr_j_r];
    rd_c_r <= pmem[addr_c_r];
  end

  logic scan_rd_r;
  fpcs_ctl_t ctl_q_r, ctl_now;
  logic [PT_W-1:0] pt_q_r;
  logic best_busy;
  logic [PT_W-1:0] best_pt;
  logic scan_end;

  assign scan_end = (scan_pt_r == PT_W'(np - 1'b1)) && (scan_dm_r == nd - 1'b1);

  always_comb begin
    ctl_now.pt_first   = scan_dm_r == '0;
    ctl_now.pt_last    = scan_dm_r == nd - 1'b1;
    ctl_now.first_pass = rank_r == 7'd1;
    ctl_now.pt_zero    = scan_pt_r == '0;
  end

  fpcs_dist_unit #(
    .COORD_WIDTH(COORD_WIDTH),
    .DIST_WIDTH (DIST_W),
    .PT_W       (PT_W)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_EMIT && state_nxt == ST_SCAN),
    .vld    (scan_rd_r),
    .ctl    (ctl_q_r),
    .pt     (pt_q_r),
    .a      (rd_j_r),
    .b      (rd_c_r),
    .best_pt(best_pt),
    .busy   (best_busy)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start_acc && !bad_start && kc != 7'd1) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == 3'd0 && !best_busy) state_nxt = ST_PICK;
      ST_PICK:  if (out_free) state_nxt = (rank_r == kc - 1'b1) ? ST_IDLE : ST_SCAN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state, load counter, center and rank, and drain counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_cnt_r <= '0;
      center_r   <= '0;
      rank_r     <= 7'd0;
      scan_rd_r  <= 1'b0;
      drain_r    <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      scan_rd_r <= (state_r == ST_SCAN);
      if (accept_in && !in_mode) begin
        load_cnt_r <= (wr_slot + 1'b1 >= total) ? '0 : wr_slot + 1'b1;
      end else if (start_acc) begin
        load_cnt_r <= '0;
      end
      if (start_acc && !bad_start) begin
        center_r <= PT_W'(in_first_index);
        rank_r   <= 7'd1;
      end
      if (state_r == ST_SCAN && scan_end) drain_r <= 3'd4;
      else if (drain_r != 3'd0) drain_r <= drain_r - 3'd1;
      if (state_r == ST_PICK && out_free) begin
        center_r <= best_pt;
        rank_r   <= rank_r + 7'd1;
      end
    end
  end

  // scan counters and addresses; the center base address follows the pick so the next pass sees it
  always_ff @(posedge clk) begin
    ctl_q_r <= ctl_now;
    pt_q_r  <= scan_pt_r;
    if (state_r != ST_SCAN) begin
      scan_pt_r <= '0;
      scan_dm_r <= '0;
      addr_j_r  <= '0;
      addr_c_r  <= ADDR_W'((state_r == ST_PICK) ? best_pt : center_r) * ADDR_W'(nd);
    end else begin
      addr_j_r <= addr_j_r + 1'b1;
      if (scan_dm_r == nd - 1'b1) begin
        scan_dm_r <= '0;
        scan_pt_r <= scan_pt_r + 1'b1;
        addr_c_r  <= addr_c_r - ADDR_W'(nd - 1'b1);
      end else begin
        scan_dm_r <= scan_dm_r + 1'b1;
        addr_c_r  <= addr_c_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (start_acc) begin
        ov_r    <= 1'b1;
        orank_r <= 6'd0;
        oidx_r  <= bad_start ? 10'd0 : in_first_index;
        oerr_r  <= bad_start;
        olast_r <= bad_start || kc == 7'd1;
      end else if (state_r == ST_PICK && out_free) begin
        ov_r    <= 1'b1;
        orank_r <= rank_r[5:0];
        oidx_r  <= 10'(best_pt);
        oerr_r  <= 1'b0;
        olast_r <= rank_r == kc - 1'b1;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_center_rank = orank_r;
  assign out_point_index = oidx_r;
  assign out_error       = oerr_r;
  assign out_last        = olast_r;

  property p_hold_out;
    @(posedge clk) disable iff (!rst_n) ov_r && out_stall |=> ov_r && $stable(oidx_r);
  endproperty
  a_hold_out: assert property (p_hold_out) else $error("result dropped");

  property p_busy_stall;
    @(posedge clk) disable iff (!rst_n) state_r != ST_IDLE |-> in_stall;
  endproperty
  a_busy_stall: assert property (p_busy_stall) else $error("input taken mid run");

  property p_err_last;
    @(posedge clk) disable iff (!rst_n) ov_r && oerr_r |-> olast_r;
  endproperty
  a_err_last: assert property (p_err_last) else $error("error not last");

endmodule
